>>> src/periodic_tick_rate_table_macros.svh
// ---------------------------------------------------------------------------
// Periodic tick rate table: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_TICK_RATE_TABLE_MACROS_SVH
`define PERIODIC_TICK_RATE_TABLE_MACROS_SVH

// same-cycle implication
`define PRTT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PRTT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/prtt_pkg.sv
// ---------------------------------------------------------------------------
// prtt_pkg
// Types, constants and helpers of the periodic tick rate table.
// ---------------------------------------------------------------------------
`default_nettype none

package prtt_pkg;

  localparam int unsigned MaxRequestors = 16;
  localparam int unsigned IdxW     = (MaxRequestors > 1) ? $clog2(MaxRequestors) : 1;
  localparam int unsigned CntW     = $clog2(MaxRequestors + 1);
  localparam int unsigned KeyW     = 16;
  localparam int unsigned PeriodW  = 32;
  localparam int unsigned ShiftW   = $clog2(PeriodW);
  localparam int unsigned ActionW  = 3;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [PeriodW-1:0] InitIntervalMs = 32'd10;

  // action codes
  localparam logic [ActionW-1:0] ActRegPeriod  = 3'd0;
  localparam logic [ActionW-1:0] ActRegCurrent = 3'd1;
  localparam logic [ActionW-1:0] ActRemove     = 3'd2;
  localparam logic [ActionW-1:0] ActLower      = 3'd3;
  localparam logic [ActionW-1:0] ActForceStop  = 3'd4;
  localparam logic [ActionW-1:0] ActAllow      = 3'd5;
  localparam logic [ActionW-1:0] ActResume     = 3'd6;

  // config register indexes
  localparam logic [CfgIdxW-1:0] CfgDriverAttached = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInitInterval   = 2'd1;

  typedef enum logic [CmdW-1:0] {
    CmdNone  = 2'd0,
    CmdStart = 2'd1,
    CmdSet   = 2'd2,
    CmdStop  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [PeriodW-1:0] period;
  } entry_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] addr;
    entry_t          data;
  } wr_req_t;

  typedef struct packed {
    logic            clr;
    logic [IdxW-1:0] addr;
  } clr_req_t;

  function automatic logic [CntW-1:0] popcount(input logic [MaxRequestors-1:0] v);
    logic [CntW-1:0] n;
    n = '0;
    for (int i = 0; i < MaxRequestors; i++) begin
      n = n + CntW'(v[i]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> src/prtt_store.sv
// ---------------------------------------------------------------------------
// prtt_store
// Entry memory (key, period) with one registered read port, plus valid bits.
// ---------------------------------------------------------------------------
`default_nettype none

module prtt_store (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [prtt_pkg::IdxW-1:0]              rd_addr_i,
  output prtt_pkg::entry_t                       rd_data_o,
  input  prtt_pkg::wr_req_t                      wr_i,
  input  prtt_pkg::clr_req_t                     clr_i,
  output logic [prtt_pkg::MaxRequestors-1:0]     valid_o
);
  import prtt_pkg::*;

  entry_t                   mem_q [MaxRequestors];
  entry_t                   rd_data_q;
  logic [MaxRequestors-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (wr_i.we) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (clr_i.clr) begin
        valid_q[clr_i.addr] <= 1'b0;
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign valid_o   = valid_q;

endmodule

`default_nettype wire

>>> src/prtt_gcd.sv
// ---------------------------------------------------------------------------
// prtt_gcd
// Binary GCD of two nonzero operands, one shift or subtract step per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
`include "periodic_tick_rate_table_macros.svh"

module prtt_gcd (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [prtt_pkg::PeriodW-1:0] op_a_i,
  input  logic [prtt_pkg::PeriodW-1:0] op_b_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [prtt_pkg::PeriodW-1:0] result_o
);
  import prtt_pkg::*;

  logic [PeriodW-1:0] a_q, b_q, res_q;
  logic [ShiftW-1:0]  k_q;
  logic               busy_q, done_q;
  logic [PeriodW-1:0] a_minus_b, b_minus_a;

  assign a_minus_b = a_q - b_q;
  assign b_minus_a = b_q - a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      k_q    <= '0;
      res_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        a_q    <= op_a_i;
        b_q    <= op_b_i;
        k_q    <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (a_q == b_q) begin
          res_q  <= a_q << k_q;
          done_q <= 1'b1;
          busy_q <= 1'b0;
        end else if (!a_q[0] && !b_q[0]) begin
          // common factor of two
          a_q <= a_q >> 1;
          b_q <= b_q >> 1;
          k_q <= k_q + ShiftW'(1);
        end else if (!a_q[0]) begin
          a_q <= a_q >> 1;
        end else if (!b_q[0]) begin
          b_q <= b_q >> 1;
        end else if (a_q > b_q) begin
          a_q <= a_minus_b >> 1;
        end else begin
          b_q <= b_minus_a >> 1;
        end
      end
    end
  end

  assign busy_o   = busy_q;
  assign done_o   = done_q;
  assign result_o = res_q;

  `PRTT_ASSERT_IMP(a_gcd_start_idle, start_i, !busy_q, "gcd started while busy")
  `PRTT_ASSERT_NXT(a_gcd_done_pulse, done_q, !done_q, "gcd done longer than one cycle")
  `PRTT_ASSERT_IMP(a_gcd_res_nonzero, done_q, res_q != '0, "gcd of nonzero operands is zero")

endmodule

`default_nettype wire

>>> src/periodic_tick_rate_table.sv
// ---------------------------------------------------------------------------
// periodic_tick_rate_table
// Keyed requestor table with a shared tick interval (GCD of all periods)
// and the command stream for a periodic timer driver.
// ---------------------------------------------------------------------------
// Actions 3 to 7 go from decode straight to the finish state, which registers the strobe.
// Register/remove actions scan the entry memory (a read and a compare state per
// entry until a hit; actions 0 and 2 skip it for key zero), and actions 0 and 2,
// unless rejected, then sweep it through the binary GCD unit entry by entry.
// One item at a time: busy is high from the start transfer to the strobe; the
// receiver cannot stall. Reset: table empty, interval 10, no stop, no driver.
// ---------------------------------------------------------------------------
`default_nettype none
`include "periodic_tick_rate_table_macros.svh"

module periodic_tick_rate_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command side
  input  logic                          start,
  output logic                          busy,
  input  logic [prtt_pkg::ActionW-1:0]  action_i,
  input  logic [prtt_pkg::KeyW-1:0]     requestor_id_i,
  input  logic [prtt_pkg::PeriodW-1:0]  period_ms_i,
  // result side, one-cycle strobe, no back-pressure
  output logic                          result_valid_o,
  output logic [prtt_pkg::PeriodW-1:0]  shared_interval_ms_o,
  output logic                          periodic_active_o,
  output logic [prtt_pkg::CmdW-1:0]     driver_command_o,
  output logic [prtt_pkg::PeriodW-1:0]  command_interval_ms_o,
  output logic                          table_full_reject_o,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [prtt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [prtt_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import prtt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FIND_RD,
    S_FIND_CMP,
    S_UPDATE,
    S_GCD_NEXT,
    S_GCD_DATA,
    S_GCD_WAIT,
    S_FINISH
  } state_e;

  // scan counter runs one past the last entry to mark the end of a sweep
  localparam logic [IdxW:0] IdxLast = (IdxW + 1)'(MaxRequestors - 1);
  localparam logic [IdxW:0] IdxEnd  = (IdxW + 1)'(MaxRequestors);
  localparam logic [IdxW:0] IdxOne  = (IdxW + 1)'(1);

  state_e              state_q;
  logic [ActionW-1:0]  action_q;
  logic [KeyW-1:0]     key_q;
  logic [PeriodW-1:0]  period_q;
  logic [IdxW:0]       idx_q;
  logic [IdxW-1:0]     slot_q;
  logic                found_q;
  logic                reject_q;
  logic                flag_q;    // lower taken / forced stop was set
  logic                any_q;     // GCD sweep has seen an entry
  logic [PeriodW-1:0]  g_q;       // running GCD
  logic [PeriodW-1:0]  cur_q;     // current shared interval
  logic                forced_q;
  logic                drv_q;

  logic                result_valid_q;
  logic [PeriodW-1:0]  shared_q;
  logic                active_q;
  logic [CmdW-1:0]     cmd_q;
  logic [PeriodW-1:0]  cmd_iv_q;
  logic                reject_out_q;

  // store interface
  logic [IdxW-1:0]          idx_lo;
  entry_t                   rd_data;
  wr_req_t                  wr_req;
  clr_req_t                 clr_req;
  logic [MaxRequestors-1:0] valid;

  // gcd interface
  logic                gcd_start, gcd_busy, gcd_done;
  logic [PeriodW-1:0]  gcd_res;

  logic                free_found;
  logic [IdxW-1:0]     free_slot;
  logic                reg_act;
  logic                can_store;
  logic [CntW-1:0]     cnt;
  cmd_e                fin_cmd;
  logic [PeriodW-1:0]  fin_iv;

  assign idx_lo = idx_q[IdxW-1:0];
  assign busy   = (state_q != S_IDLE);
  assign cnt    = popcount(valid);

  // first free entry
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = 0; i < MaxRequestors; i++) begin
      if (!valid[i] && !free_found) begin
        free_found = 1'b1;
        free_slot  = IdxW'(i);
      end
    end
  end

  // memory write / valid clear, issued from the update state
  always_comb begin
    reg_act   = (action_q == ActRegPeriod) || (action_q == ActRegCurrent);
    can_store = found_q || free_found;

    wr_req.we          = (state_q == S_UPDATE) && reg_act && can_store;
    wr_req.addr        = found_q ? slot_q : free_slot;
    wr_req.data.key    = key_q;
    wr_req.data.period = (action_q == ActRegCurrent) ? cur_q : period_q;

    clr_req.clr  = (state_q == S_UPDATE) && (action_q == ActRemove) && found_q;
    clr_req.addr = slot_q;
  end

  // a zero on either side forces the running GCD to zero without the unit
  assign gcd_start = (state_q == S_GCD_DATA) && any_q &&
                     (rd_data.period != '0) && (g_q != '0);

  // driver command, from state already committed
  always_comb begin
    fin_cmd = CmdNone;
    fin_iv  = '0;
    unique case (action_q)
      ActRegPeriod: begin
        if (!reject_q && drv_q) begin
          fin_cmd = CmdStart;
          fin_iv  = cur_q;
        end
      end
      ActRegCurrent: begin
        if (!reject_q && drv_q && (cnt == CntW'(1))) begin
          fin_cmd = CmdStart;
          fin_iv  = cur_q;
        end
      end
      ActRemove: begin
        if (drv_q) begin
          if (cnt != '0) begin
            fin_cmd = CmdSet;
            fin_iv  = cur_q;
          end else begin
            fin_cmd = CmdStop;
          end
        end
      end
      ActLower: begin
        if (flag_q) begin
          fin_cmd = CmdSet;
          fin_iv  = cur_q;
        end
      end
      ActForceStop: begin
        if (drv_q) begin
          fin_cmd = CmdStop;
        end
      end
      ActAllow: begin
        if (flag_q && drv_q && (cnt != '0)) begin
          fin_cmd = CmdStart;
          fin_iv  = cur_q;
        end
      end
      ActResume: begin
        if (!forced_q && drv_q) begin
          fin_cmd = CmdStart;
          fin_iv  = cur_q;
        end
      end
      default: begin
        fin_cmd = CmdNone;
      end
    endcase
  end

  // sequencer: decode, key scan, update, GCD sweep, finish
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      action_q       <= '0;
      key_q          <= '0;
      period_q       <= '0;
      idx_q          <= '0;
      slot_q         <= '0;
      found_q        <= 1'b0;
      reject_q       <= 1'b0;
      flag_q         <= 1'b0;
      any_q          <= 1'b0;
      g_q            <= '0;
      cur_q          <= InitIntervalMs;
      forced_q       <= 1'b0;
      drv_q          <= 1'b0;
      result_valid_q <= 1'b0;
      shared_q       <= '0;
      active_q       <= 1'b0;
      cmd_q          <= '0;
      cmd_iv_q       <= '0;
      reject_out_q   <= 1'b0;
    end else begin
      result_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            action_q <= action_i;
            key_q    <= requestor_id_i;
            period_q <= period_ms_i;
            idx_q    <= '0;
            found_q  <= 1'b0;
            reject_q <= 1'b0;
            flag_q   <= 1'b0;
            any_q    <= 1'b0;
            state_q  <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (action_q) inside
            ActRegPeriod, ActRemove: begin
              // key zero skips the table and only recomputes
              state_q <= (key_q != '0) ? S_FIND_RD : S_GCD_NEXT;
            end
            ActRegCurrent: begin
              state_q <= S_FIND_RD;
            end
            ActLower: begin
              if ((period_q < cur_q) && drv_q) begin
                cur_q  <= period_q;
                flag_q <= 1'b1;
              end
              state_q <= S_FINISH;
            end
            ActForceStop: begin
              forced_q <= 1'b1;
              state_q  <= S_FINISH;
            end
            ActAllow: begin
              flag_q   <= forced_q;
              forced_q <= 1'b0;
              state_q  <= S_FINISH;
            end
            default: begin
              state_q <= S_FINISH;
            end
          endcase
        end
        S_FIND_RD: begin
          state_q <= S_FIND_CMP;
        end
        S_FIND_CMP: begin
          if (valid[idx_lo] && (rd_data.key == key_q)) begin
            found_q <= 1'b1;
            slot_q  <= idx_lo;
            state_q <= S_UPDATE;
          end else if (idx_q == IdxLast) begin
            state_q <= S_UPDATE;
          end else begin
            idx_q   <= idx_q + IdxOne;
            state_q <= S_FIND_RD;
          end
        end
        S_UPDATE: begin
          idx_q <= '0;
          if (action_q == ActRemove) begin
            state_q <= S_GCD_NEXT;
          end else if (!can_store) begin
            reject_q <= 1'b1;
            state_q  <= S_FINISH;
          end else if (action_q == ActRegPeriod) begin
            state_q <= S_GCD_NEXT;
          end else begin
            state_q <= S_FINISH;
          end
        end
        S_GCD_NEXT: begin
          if (idx_q == IdxEnd) begin
            // empty table keeps the interval it had
            if (any_q) begin
              cur_q <= g_q;
            end
            state_q <= S_FINISH;
          end else if (valid[idx_lo]) begin
            state_q <= S_GCD_DATA;
          end else begin
            idx_q <= idx_q + IdxOne;
          end
        end
        S_GCD_DATA: begin
          if (!any_q) begin
            g_q     <= rd_data.period;
            any_q   <= 1'b1;
            idx_q   <= idx_q + IdxOne;
            state_q <= S_GCD_NEXT;
          end else if (gcd_start) begin
            state_q <= S_GCD_WAIT;
          end else begin
            g_q     <= '0;
            idx_q   <= idx_q + IdxOne;
            state_q <= S_GCD_NEXT;
          end
        end
        S_GCD_WAIT: begin
          if (gcd_done) begin
            g_q     <= gcd_res;
            idx_q   <= idx_q + IdxOne;
            state_q <= S_GCD_NEXT;
          end
        end
        S_FINISH: begin
          result_valid_q <= 1'b1;
          shared_q       <= cur_q;
          active_q       <= (cnt != '0) && !forced_q;
          cmd_q          <= fin_cmd;
          cmd_iv_q       <= fin_iv;
          reject_out_q   <= reject_q;
          state_q        <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // the user must make config writes only while idle; the block does no check; interval write reloads at once
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgDriverAttached: drv_q <= cfg_wdata_i[0];
          CfgInitInterval:   cur_q <= cfg_wdata_i[PeriodW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  prtt_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (idx_lo),
    .rd_data_o (rd_data),
    .wr_i      (wr_req),
    .clr_i     (clr_req),
    .valid_o   (valid)
  );

  prtt_gcd u_gcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (gcd_start),
    .op_a_i   (rd_data.period),
    .op_b_i   (g_q),
    .busy_o   (gcd_busy),
    .done_o   (gcd_done),
    .result_o (gcd_res)
  );

  assign result_valid_o        = result_valid_q;
  assign shared_interval_ms_o  = shared_q;
  assign periodic_active_o     = active_q;
  assign driver_command_o      = cmd_q;
  assign command_interval_ms_o = cmd_iv_q;
  assign table_full_reject_o   = reject_out_q;

  `PRTT_ASSERT_NXT(a_strobe_single, result_valid_q, !result_valid_q, "result strobe held")
  `PRTT_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item not busy")
  `PRTT_ASSERT_IMP(a_wait_gcd, state_q == S_GCD_WAIT, gcd_busy || gcd_done, "waiting on idle gcd")
  `PRTT_ASSERT_IMP(a_reject_quiet, result_valid_q && reject_out_q, cmd_q == CmdNone, "reject with command")
  `PRTT_ASSERT_IMP(a_iv_zero, result_valid_q && (cmd_q == CmdNone || cmd_q == CmdStop), cmd_iv_q == '0, "interval without start/set")

endmodule

`default_nettype wire

>>> bench/tb_periodic_tick_rate_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_periodic_tick_rate_table
// Self-checking bench for the periodic tick rate table. Actions go in through
// the start/busy handshake. A local table model predicts the interval, the
// active flag, the timer command and the reject flag for each transfer. The
// result strobe is checked against the oldest prediction. Config changes
// between phases cover both driver settings and the interval extremes.
// ---------------------------------------------------------------------------
module tb_periodic_tick_rate_table;
  import prtt_pkg::*;

  // codes the package does not name
  localparam logic [ActionW-1:0] ActUnused = 3'd7;
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  // Worst case per item comes with a full table and long GCD chains; the
  // watchdog limit lies well above it, counted while nothing makes progress.
  localparam int unsigned IdleLimit   = 20000;
  localparam int unsigned DrainCycles = 1200;
  localparam int unsigned PoolSize    = 20;
  localparam int unsigned PhaseItems  = 92;

  typedef struct {
    logic [ActionW-1:0] act;
    logic [KeyW-1:0]    id;
    logic [PeriodW-1:0] per;
    bit                 drain;  // hold until all pending results are back
  } tick_req_t;

  typedef struct {
    logic [PeriodW-1:0] interval;
    logic               active;
    cmd_e               cmd;
    logic [PeriodW-1:0] cmd_iv;
    logic               reject;
  } tick_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                start          = 1'b0;
  logic                busy;
  logic [ActionW-1:0]  action_i       = ActRegPeriod;
  logic [KeyW-1:0]     requestor_id_i = '0;
  logic [PeriodW-1:0]  period_ms_i    = '0;
  logic                result_valid_o;
  logic [PeriodW-1:0]  shared_interval_ms_o;
  logic                periodic_active_o;
  logic [CmdW-1:0]     driver_command_o;
  logic [PeriodW-1:0]  command_interval_ms_o;
  logic                table_full_reject_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = CfgDriverAttached;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  periodic_tick_rate_table uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .action_i             (action_i),
    .requestor_id_i       (requestor_id_i),
    .period_ms_i          (period_ms_i),
    .result_valid_o       (result_valid_o),
    .shared_interval_ms_o (shared_interval_ms_o),
    .periodic_active_o    (periodic_active_o),
    .driver_command_o     (driver_command_o),
    .command_interval_ms_o(command_interval_ms_o),
    .table_full_reject_o  (table_full_reject_o),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Table model: entry flags, keys, periods, the shared interval, the stop
  // latch and the two config values. Slot order does not matter for any
  // output, since the GCD of the stored periods is order independent.
  // -------------------------------------------------------------------------
  bit                 tbl_used   [MaxRequestors];
  logic [KeyW-1:0]    tbl_key    [MaxRequestors];
  logic [PeriodW-1:0] tbl_period [MaxRequestors];
  logic [PeriodW-1:0] tick_interval = InitIntervalMs;
  bit                 tick_stopped  = 1'b0;
  bit                 drv_present   = 1'b0;

  tick_req_t    requests_queued[$];   // waiting for the driver
  tick_result_t tick_results_due[$];  // predicted, waiting for the strobe
  tick_result_t result_due;
  logic [KeyW-1:0] key_pool [PoolSize];

  int  gap_left   = 0;
  int  idle_cycles = 0;
  int  n_fail     = 0;
  bit  no_gaps    = 1'b0;
  bit  req_fire;
  tick_req_t req_next;

  // Euclid; a zero on either side gives zero
  function automatic logic [PeriodW-1:0] gcd_u32(input logic [PeriodW-1:0] a,
                                                 input logic [PeriodW-1:0] b);
    logic [PeriodW-1:0] r;
    if (a == '0 || b == '0) return '0;
    r = a % b;
    while (r != '0) begin
      a = b;
      b = r;
      r = a % b;
    end
    return b;
  endfunction

  function automatic int used_count();
    int n;
    n = 0;
    for (int i = 0; i < MaxRequestors; i++) n += tbl_used[i];
    return n;
  endfunction

  // empty table keeps the interval it had
  function automatic logic [PeriodW-1:0] table_gcd();
    logic [PeriodW-1:0] g;
    bit seen;
    g = tick_interval;
    seen = 1'b0;
    for (int i = 0; i < MaxRequestors; i++) begin
      if (tbl_used[i]) begin
        if (!seen) begin
          g = tbl_period[i];
          seen = 1'b1;
        end else begin
          g = gcd_u32(tbl_period[i], g);
        end
      end
    end
    return g;
  endfunction

  function automatic int find_slot(input logic [KeyW-1:0] id);
    for (int i = 0; i < MaxRequestors; i++)
      if (tbl_used[i] && tbl_key[i] == id) return i;
    return -1;
  endfunction

  // update in place or take the first free slot; 0 when the table is full
  function automatic bit store_requestor(input logic [KeyW-1:0] id,
                                         input logic [PeriodW-1:0] per);
    int slot;
    slot = find_slot(id);
    if (slot < 0)
      for (int i = 0; i < MaxRequestors; i++)
        if (!tbl_used[i] && slot < 0) slot = i;
    if (slot < 0) return 1'b0;
    tbl_used[slot]   = 1'b1;
    tbl_key[slot]    = id;
    tbl_period[slot] = per;
    return 1'b1;
  endfunction

  // Applies one action to the table model and returns the result it gives.
  function automatic tick_result_t apply_tick_action(input logic [ActionW-1:0] act,
                                                     input logic [KeyW-1:0] id,
                                                     input logic [PeriodW-1:0] per);
    tick_result_t res;
    int slot;
    res.cmd    = CmdNone;
    res.cmd_iv = '0;
    res.reject = 1'b0;
    case (act)
      ActRegPeriod: begin
        // key 0 stores nothing but still forces a recompute
        if (id != '0 && !store_requestor(id, per)) begin
          res.reject = 1'b1;
        end else begin
          tick_interval = table_gcd();
          if (drv_present) begin
            res.cmd    = CmdStart;
            res.cmd_iv = tick_interval;
          end
        end
      end
      ActRegCurrent: begin
        // key 0 is an ordinary key here; no recompute
        if (!store_requestor(id, tick_interval)) begin
          res.reject = 1'b1;
        end else if (drv_present && used_count() == 1) begin
          res.cmd    = CmdStart;
          res.cmd_iv = tick_interval;
        end
      end
      ActRemove: begin
        if (id != '0) begin
          slot = find_slot(id);
          if (slot >= 0) tbl_used[slot] = 1'b0;
        end
        tick_interval = table_gcd();
        if (drv_present) begin
          if (used_count() > 0) begin
            res.cmd    = CmdSet;
            res.cmd_iv = tick_interval;
          end else begin
            res.cmd = CmdStop;
          end
        end
      end
      ActLower: begin
        // needs a driver, and strictly lower
        if (per < tick_interval && drv_present) begin
          tick_interval = per;
          res.cmd       = CmdSet;
          res.cmd_iv    = tick_interval;
        end
      end
      ActForceStop: begin
        tick_stopped = 1'b1;
        if (drv_present) res.cmd = CmdStop;
      end
      ActAllow: begin
        if (tick_stopped) begin
          tick_stopped = 1'b0;
          if (drv_present && used_count() > 0) begin
            res.cmd    = CmdStart;
            res.cmd_iv = tick_interval;
          end
        end
      end
      ActResume: begin
        if (!tick_stopped && drv_present) begin
          res.cmd    = CmdStart;
          res.cmd_iv = tick_interval;
        end
      end
      default: begin
      end
    endcase
    res.interval = tick_interval;
    res.active   = (used_count() > 0) && !tick_stopped;
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  function automatic int pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // mostly a small pool so keys repeat and the table fills up
  function automatic logic [KeyW-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return KeyW'($urandom);
    return key_pool[$urandom_range(0, PoolSize - 1)];
  endfunction

  // periods with common factors so the GCD is not always 1
  function automatic logic [PeriodW-1:0] pick_period();
    int unsigned r;
    int unsigned b;
    r = $urandom_range(0, 99);
    if (r < 2) return '0;
    if (r < 5) return '1;
    if (r < 15) return $urandom;
    case ($urandom_range(0, 3))
      0:       b = 2;
      1:       b = 5;
      2:       b = 10;
      default: b = 3;
    endcase
    return PeriodW'(b * $urandom_range(1, 64));
  endfunction

  function automatic tick_req_t draw_request();
    tick_req_t q;
    int unsigned r;
    q.act   = ActUnused;
    q.id    = KeyW'($urandom);
    q.per   = $urandom;
    q.drain = ($urandom_range(0, 59) == 0);
    r = $urandom_range(0, 99);
    if (r < 30) begin
      q.act = ActRegPeriod;
      q.id  = pick_key();
      q.per = pick_period();
    end else if (r < 42) begin
      q.act = ActRegCurrent;
      q.id  = pick_key();
    end else if (r < 64) begin
      q.act = ActRemove;
      q.id  = pick_key();
    end else if (r < 72) begin
      q.act = ActLower;
      q.per = ($urandom_range(0, 1) != 0) ? PeriodW'($urandom_range(0, 300)) : $urandom;
    end else if (r < 78) begin
      q.act = ActForceStop;
    end else if (r < 86) begin
      q.act = ActAllow;
    end else if (r < 94) begin
      q.act = ActResume;
    end
    return q;
  endfunction

  function automatic void queue_request(input logic [ActionW-1:0] act,
                                        input logic [KeyW-1:0] id,
                                        input logic [PeriodW-1:0] per);
    tick_req_t q;
    q.act   = act;
    q.id    = id;
    q.per   = per;
    q.drain = 1'b0;
    requests_queued.push_back(q);
  endfunction

  // only called while idle, so the model can follow the write at once
  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgDriverAttached: drv_present = data[0];
      CfgInitInterval:   tick_interval = data;  // also reloads the live interval
      default: begin
      end
    endcase
  endtask

  task automatic wait_idle();
    while (requests_queued.size() != 0 || tick_results_due.size() != 0 || start || busy)
      @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input logic [PeriodW-1:0] want,
                                      input logic [PeriodW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endfunction

  // -------------------------------------------------------------------------
  // Driver: presents queued actions, predicts each one at its transfer edge.
  // start stays high across back-to-back items; it gets one update per edge.
  // -------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start          <= 1'b0;
      action_i       <= ActRegPeriod;
      requestor_id_i <= '0;
      period_ms_i    <= '0;
    end else begin
      req_fire = start && !busy;
      if (req_fire) begin
        tick_results_due.push_back(apply_tick_action(action_i, requestor_id_i, period_ms_i));
        gap_left = pick_gap();
      end
      if (!start || req_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (requests_queued.size() != 0 &&
                     !(requests_queued[0].drain && tick_results_due.size() != 0)) begin
          req_next = requests_queued.pop_front();
          start          <= 1'b1;
          action_i       <= req_next.act;
          requestor_id_i <= req_next.id;
          period_ms_i    <= req_next.per;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: every strobe must match the oldest prediction, field by field.
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (tick_results_due.size() == 0) begin
        $error("result strobe with no request outstanding");
        n_fail++;
      end else begin
        result_due = tick_results_due.pop_front();
        check_field("shared_interval_ms", result_due.interval, shared_interval_ms_o);
        check_field("periodic_active", PeriodW'(result_due.active), PeriodW'(periodic_active_o));
        check_field("driver_command", PeriodW'(result_due.cmd), PeriodW'(driver_command_o));
        check_field("command_interval_ms", result_due.cmd_iv, command_interval_ms_o);
        check_field("table_full_reject", PeriodW'(result_due.reject),
                    PeriodW'(table_full_reject_o));
      end
    end
  end

  // watchdog: any transfer, strobe or register write counts as progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o || cfg_we_i) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sequence: reset, directed checks, then random phases with config changes
  // -------------------------------------------------------------------------
  initial begin
    logic [PeriodW-1:0] iv;
    tick_req_t q;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) key_pool[i] = KeyW'($urandom);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset config: no driver, interval 10; state still changes, no commands
    queue_request(ActRegPeriod, 16'h0005, 32'd30);
    queue_request(ActLower, 16'h0000, 32'd3);
    queue_request(ActRemove, 16'h0005, 32'd0);
    wait_idle();

    write_cfg(CfgDriverAttached, {31'($urandom), 1'b1});
    write_cfg(CfgInitInterval, 32'hFFFF_FFFF);
    // indexes past the register list must be ignored
    write_cfg(CfgSpareA, $urandom);
    write_cfg(CfgSpareB, $urandom);

    // fill the table: key 0 at the current interval, then 15 more keys
    queue_request(ActRegCurrent, 16'h0000, $urandom);
    for (int k = 1; k <= 14; k++)
      queue_request(ActRegPeriod, 16'hFFFF ^ KeyW'(k - 1), PeriodW'(60 * k));
    queue_request(ActRegPeriod, 16'h0001, 32'h8000_0000);
    // full: new keys are rejected on both register actions
    queue_request(ActRegPeriod, 16'h0002, 32'd7);
    queue_request(ActRegCurrent, 16'h0003, 32'd0);
    // key 0 with period means no requestor: recompute only
    queue_request(ActRegPeriod, 16'h0000, 32'd123);
    // a stored zero period pulls the interval to zero
    queue_request(ActRegPeriod, 16'hFFFF, 32'd0);
    queue_request(ActRemove, 16'h0000, 32'd0);
    queue_request(ActRemove, 16'hFFFF, 32'd0);
    queue_request(ActLower, 16'hFFFF, 32'd0);
    queue_request(ActForceStop, 16'h0000, 32'd0);
    queue_request(ActResume, 16'h0000, 32'd0);   // stopped: no command
    queue_request(ActAllow, 16'h0000, 32'd0);
    queue_request(ActUnused, 16'hFFFF, 32'hFFFF_FFFF);

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_cfg(CfgDriverAttached, {31'($urandom), (ph == 1 || ph == 4) ? 1'b0 : 1'b1});
      case (ph % 4)
        0:       iv = '0;
        1:       iv = '1;
        2:       iv = PeriodW'($urandom_range(1, 1000));
        default: iv = $urandom;
      endcase
      write_cfg(CfgInitInterval, iv);
      no_gaps = (ph == 2);
      for (int n = 0; n < PhaseItems; n++) begin
        q = draw_request();
        if (n == 40) q.drain = 1'b1;
        requests_queued.push_back(q);
      end
    end

    wait_idle();
    // a stray strobe after the last result would show up here
    repeat (DrainCycles) @(posedge clk_i);
    if (tick_results_due.size() != 0) begin
      $error("%0d results never arrived", tick_results_due.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
